// File: rtl/spmw_pkg.sv
// Shared types, constants and helper functions for the starfield star update block.
// Used by star_position_move_and_wrap; depends on nothing else.
package spmw_pkg;

  localparam int FRAC_BITS = 16;
  localparam int N_STAGES  = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 32;

  // Q-format one at the widths where it is used
  localparam logic signed [32:0] ONE33 = 33'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] ONE64 = 64'sd1 <<< FRAC_BITS;

  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_SPEED   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_CAL    = 3'd6;

  typedef enum logic [2:0] {
    LOCK_NONE   = 3'd0,
    LOCK_FRONT  = 3'd1,
    LOCK_BACK   = 3'd2,
    LOCK_LEFT   = 3'd3,
    LOCK_RIGHT  = 3'd4,
    LOCK_TOP    = 3'd5,
    LOCK_BOTTOM = 3'd6
  } lock_t;

  typedef struct packed {
    logic              opcode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic signed [31:0] delta_z;
    logic signed [31:0] rand_x;
    logic signed [31:0] rand_y;
    logic        [30:0] rand_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic        [2:0]  wrap_edge;
  } out_t;

  typedef struct packed {
    logic signed [31:0] slice_left;
    logic signed [31:0] slice_top;
    logic signed [31:0] slice_right;
    logic signed [31:0] slice_bottom;
    logic        [30:0] max_depth;
    logic        [30:0] move_speed;
    logic        [15:0] depth_cal;
  } cfg_t;

  // star position on its way through the wrap stages
  typedef struct packed {
    logic               pan;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    lock_t              lock;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic        [30:0] rz;
  } work_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = S32_MAX[31:0];
    end else if (v < S32_MIN) begin
      r = S32_MIN[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // locked coordinate goes to the opposite edge, free ones take the random draw
  function automatic work_t respawn(input work_t w, input lock_t lk, input cfg_t c);
    work_t r;
    r      = w;
    r.lock = lk;
    r.z    = (lk == LOCK_FRONT) ? 32'sd0 :
             (lk == LOCK_BACK)  ? $signed({1'b0, c.max_depth}) :
                                  $signed({1'b0, w.rz});
    r.x    = (lk == LOCK_LEFT)  ? c.slice_left :
             (lk == LOCK_RIGHT) ? c.slice_right : w.rx;
    r.y    = (lk == LOCK_TOP)   ? c.slice_top :
             (lk == LOCK_BOTTOM) ? c.slice_bottom : w.ry;
    return r;
  endfunction

endpackage

// File: rtl/star_position_move_and_wrap.sv
// Starfield star update: move or pan one star, then depth, x and y wrap with respawn.
// Depends on spmw_pkg for payload types, config indexes, lock codes and helpers.
// Seven register stages from input transaction to result valid, output register included.
// Throughput: one star per cycle while out_ready is high; every stage holds one star
// and advances when the stage after it is empty or advancing, so a stall loses nothing
// and bubbles collapse.
// Reset: synchronous active-low rst_n clears all stage valid bits and loads the
// configuration defaults (slice edges 0, max depth 0, speed 1.0, calibration 66).
module star_position_move_and_wrap (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  spmw_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output spmw_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [spmw_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [spmw_pkg::CFG_DW-1:0]         cfg_wdata
);

  spmw_pkg::cfg_t cfg_r;

  logic [spmw_pkg::N_STAGES-1:0] vld_r;
  logic [spmw_pkg::N_STAGES-1:0] vld_nxt;
  logic [spmw_pkg::N_STAGES:0]   rdy;

  // stage A: pan factor product
  spmw_pkg::in_t      a_r;
  logic signed [49:0] a_pf_r;
  logic signed [32:0] a_zp;
  logic signed [49:0] a_pf_nxt;

  // stage B: multiplier operand
  spmw_pkg::in_t      b_r;
  logic signed [31:0] b_mul_r;
  logic signed [49:0] b_shift;
  logic signed [63:0] b_fx;
  logic signed [31:0] b_mul_nxt;

  // stage C: vector products
  spmw_pkg::in_t      c_r;
  logic signed [63:0] c_px_r;
  logic signed [63:0] c_py_r;
  logic signed [63:0] c_pz_r;
  logic signed [63:0] c_px_nxt;
  logic signed [63:0] c_py_nxt;
  logic signed [63:0] c_pz_nxt;

  // stage D..G: subtract and wraps
  spmw_pkg::work_t d_r, d_nxt;
  spmw_pkg::work_t e_r, e_nxt;
  spmw_pkg::work_t f_r, f_nxt;
  spmw_pkg::work_t g_r, g_nxt;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slice_left   <= '0;
      cfg_r.slice_top    <= '0;
      cfg_r.slice_right  <= '0;
      cfg_r.slice_bottom <= '0;
      cfg_r.max_depth    <= '0;
      cfg_r.move_speed   <= 31'd65536;
      cfg_r.depth_cal    <= 16'd66;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        spmw_pkg::CFG_SLICE_LEFT:   cfg_r.slice_left   <= cfg_wdata;
        spmw_pkg::CFG_SLICE_TOP:    cfg_r.slice_top    <= cfg_wdata;
        spmw_pkg::CFG_SLICE_RIGHT:  cfg_r.slice_right  <= cfg_wdata;
        spmw_pkg::CFG_SLICE_BOTTOM: cfg_r.slice_bottom <= cfg_wdata;
        spmw_pkg::CFG_MAX_DEPTH:    cfg_r.max_depth    <= cfg_wdata[30:0];
        spmw_pkg::CFG_MOVE_SPEED:   cfg_r.move_speed   <= cfg_wdata[30:0];
        spmw_pkg::CFG_DEPTH_CAL:    cfg_r.depth_cal    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // a stage takes a new transaction when it is empty or its contents move on
  always_comb begin
    rdy[spmw_pkg::N_STAGES] = out_ready;
    for (int k = spmw_pkg::N_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt = vld_r;
    for (int k = 0; k < spmw_pkg::N_STAGES; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = (k == 0) ? in_valid : vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[spmw_pkg::N_STAGES-1];

  // stage A: (1 + z) * calibration
  always_comb begin
    a_zp     = 33'(in_data.pos_z) + spmw_pkg::ONE33;
    a_pf_nxt = a_zp * $signed({1'b0, cfg_r.depth_cal});
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_r    <= in_data;
      a_pf_r <= a_pf_nxt;
    end
  end

  // stage B: pan factor floor-shifted, minus one, saturated; move uses the speed factor
  always_comb begin
    b_shift   = a_pf_r >>> spmw_pkg::FRAC_BITS;
    b_fx      = 64'(b_shift) - spmw_pkg::ONE64;
    b_mul_nxt = a_r.opcode ? spmw_pkg::sat32(b_fx) : $signed({1'b0, cfg_r.move_speed});
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      b_r     <= a_r;
      b_mul_r <= b_mul_nxt;
    end
  end

  // stage C: three 32x32 products
  always_comb begin
    c_px_nxt = b_r.delta_x * b_mul_r;
    c_py_nxt = b_r.delta_y * b_mul_r;
    c_pz_nxt = b_r.delta_z * b_mul_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      c_r    <= b_r;
      c_px_r <= c_px_nxt;
      c_py_r <= c_py_nxt;
      c_pz_r <= c_pz_nxt;
    end
  end

  // stage D: subtract floored products and saturate; pan keeps depth
  always_comb begin
    d_nxt.pan  = c_r.opcode;
    d_nxt.x    = spmw_pkg::sat32(64'(c_r.pos_x) - (c_px_r >>> spmw_pkg::FRAC_BITS));
    d_nxt.y    = spmw_pkg::sat32(64'(c_r.pos_y) - (c_py_r >>> spmw_pkg::FRAC_BITS));
    d_nxt.z    = c_r.opcode ? c_r.pos_z
               : spmw_pkg::sat32(64'(c_r.pos_z) - (c_pz_r >>> spmw_pkg::FRAC_BITS));
    d_nxt.lock = spmw_pkg::LOCK_NONE;
    d_nxt.rx   = c_r.rand_x;
    d_nxt.ry   = c_r.rand_y;
    d_nxt.rz   = c_r.rand_z;
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      d_r <= d_nxt;
    end
  end

  // stage E: depth wrap, move only
  always_comb begin
    e_nxt = d_r;
    if (!d_r.pan) begin
      if (d_r.z < 32'sd0) begin
        e_nxt = spmw_pkg::respawn(d_r, spmw_pkg::LOCK_BACK, cfg_r);
      end else if (d_r.z > $signed({1'b0, cfg_r.max_depth})) begin
        e_nxt = spmw_pkg::respawn(d_r, spmw_pkg::LOCK_FRONT, cfg_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      e_r <= e_nxt;
    end
  end

  // stage F: x wrap
  always_comb begin
    f_nxt = e_r;
    if (e_r.x < cfg_r.slice_left) begin
      f_nxt = spmw_pkg::respawn(e_r, spmw_pkg::LOCK_RIGHT, cfg_r);
    end else if (e_r.x > cfg_r.slice_right) begin
      f_nxt = spmw_pkg::respawn(e_r, spmw_pkg::LOCK_LEFT, cfg_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      f_r <= f_nxt;
    end
  end

  // stage G: y wrap into the output register
  always_comb begin
    g_nxt = f_r;
    if (f_r.y < cfg_r.slice_top) begin
      g_nxt = spmw_pkg::respawn(f_r, spmw_pkg::LOCK_BOTTOM, cfg_r);
    end else if (f_r.y > cfg_r.slice_bottom) begin
      g_nxt = spmw_pkg::respawn(f_r, spmw_pkg::LOCK_TOP, cfg_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      g_r <= g_nxt;
    end
  end

  assign out_data.new_x     = g_r.x;
  assign out_data.new_y     = g_r.y;
  assign out_data.new_z     = g_r.z;
  assign out_data.wrap_edge = g_r.lock;

endmodule
